FILE: design/qrm_pkg.sv
// Package for the queue with rotate-to-maximum unit.
// Holds the operation and status codes and the fixed field widths.
// No dependencies.
`default_nettype none

package qrm_pkg;

  // Fixed field widths of one item and one result.
  localparam int unsigned OpW    = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 5;

  // Operation codes.
  localparam logic [OpW-1:0] OP_PUSH   = 2'd0;
  localparam logic [OpW-1:0] OP_POP    = 2'd1;
  localparam logic [OpW-1:0] OP_ROTATE = 2'd2;
  localparam logic [OpW-1:0] OP_CLEAR  = 2'd3;

  // Status codes.
  localparam logic [StatW-1:0] ST_DONE  = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;

endpackage : qrm_pkg

`default_nettype wire

FILE: design/queue_with_rotate_to_max_unit.sv
// Top level of the queue with rotate-to-maximum unit.
// Depends on qrm_pkg for codes and field widths.
`default_nettype none

// A bounded FIFO of signed Q16.16 values held in a circular memory with one
// registered read port and one write port. An item is taken when start is high
// and busy is low; busy stays high until the result has been shown. Each item
// gives exactly one result on result_valid_o, high for a single cycle, and the
// receiver must take it then. Push, pop and clear step through the update in
// the accepting cycle, a read of the head entry and the result. A rotate
// first walks the memory port once over all held entries to find the first
// maximum; unless that maximum already sits at the head, it then walks once
// over the entries ahead of it to append them at the tail, and the head moves
// to the maximum. A read of the head entry and the result follow.
module queue_with_rotate_to_max_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    start,
  output logic                                   busy,
  input  wire  [qrm_pkg::OpW-1:0]                operation_i,
  input  wire  signed [qrm_pkg::DataW-1:0]       value_i,
  output logic                                   result_valid_o,
  output logic [qrm_pkg::StatW-1:0]              status_o,
  output logic [qrm_pkg::CountW-1:0]             count_o,
  output logic                                   front_valid_o,
  output logic signed [qrm_pkg::DataW-1:0]       front_value_o
);

  import qrm_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = CW + 1;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_COPY   = 3'd3;
  localparam logic [2:0] S_FRONT  = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  // Sum of two values not above DEPTH, reduced modulo DEPTH.
  function automatic logic [AW-1:0] add_mod(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [WW-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= WW'(DEPTH)) begin
      s = s - WW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic [2:0]              state_q, state_d;
  logic [AW-1:0]           head_q, head_d;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [CW-1:0]           k_q, k_d;
  logic                    pend_q, pend_d;
  logic [CW-1:0]           best_q, best_d;
  logic signed [DataW-1:0] max_q, max_d;
  logic [StatW-1:0]        status_q, status_d;
  logic signed [DataW-1:0] rd_data_q;

  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [DataW-1:0] wr_data;

  logic signed [DataW-1:0] mem [DEPTH];

  // Entry store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr];
  end

  // Sequencer and shared compare / address unit.
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    count_d  = count_q;
    idx_d    = idx_q;
    k_d      = k_q;
    pend_d   = 1'b0;
    best_d   = best_q;
    max_d    = max_q;
    status_d = status_q;
    rd_addr  = head_q;
    wr_en    = 1'b0;
    wr_addr  = add_mod(CW'(head_q), count_q);
    wr_data  = value_i;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          status_d = ST_DONE;
          state_d  = S_FRONT;
          unique case (operation_i)
            OP_PUSH: begin
              if (count_q >= CW'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                head_d  = add_mod(CW'(head_q), CW'(1));
                count_d = count_q - CW'(1);
              end
            end
            OP_ROTATE: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                idx_d   = '0;
                best_d  = '0;
                state_d = S_SCAN;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
              head_d  = '0;
            end
            default: begin
              state_d = S_FRONT;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Compare the entry read in the previous cycle against the running maximum.
        if (pend_q) begin
          if ((k_q == '0) || (rd_data_q > max_q)) begin
            max_d  = rd_data_q;
            best_d = k_q;
          end
        end
        // Issue the next read, or finish once every entry has been compared.
        if (idx_q < count_q) begin
          rd_addr = add_mod(CW'(head_q), idx_q);
          k_d     = idx_q;
          idx_d   = idx_q + CW'(1);
          pend_d  = 1'b1;
        end else begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        idx_d = '0;
        if (best_q == '0) begin
          state_d = S_FRONT;
        end else begin
          state_d = S_COPY;
        end
      end

      S_COPY: begin
        // Append each entry ahead of the maximum at the tail, in order.
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_addr = add_mod(CW'(head_q), CW'(add_mod(count_q, k_q)));
          wr_data = rd_data_q;
        end
        if (idx_q < best_q) begin
          rd_addr = add_mod(CW'(head_q), idx_q);
          k_d     = idx_q;
          idx_d   = idx_q + CW'(1);
          pend_d  = 1'b1;
        end else begin
          head_d  = add_mod(CW'(head_q), best_q);
          state_d = S_FRONT;
        end
      end

      S_FRONT: begin
        // Read the head entry for the result.
        rd_addr = head_q;
        state_d = S_OUT;
      end

      S_OUT: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    k_q      <= k_d;
    best_q   <= best_d;
    max_q    <= max_d;
    status_q <= status_d;
  end

  // Result ports.
  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_OUT);
  assign status_o       = status_q;
  assign count_o        = CountW'(count_q);
  assign front_valid_o  = (count_q != '0);
  assign front_value_o  = front_valid_o ? rd_data_q : '0;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("element count exceeds depth");

  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after taking an item");

  a_copy_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY) |-> ((best_q != '0) && (best_q < count_q)))
    else $error("copy pass entered with maximum at head or out of range");
`endif

endmodule : queue_with_rotate_to_max_unit

`default_nettype wire
